// File: hw/rtl/etrb_pkg.sv
// Shared constants and Q30 arithmetic for the Euler angle to rotation basis block.
`timescale 1ns / 1ps

package etrb_pkg;

	localparam int DEF_ANGLE_BITS     = 16;
	localparam int DEF_COMPONENT_BITS = 16;

	// register stages inside one sine unit
	localparam int SINE_STAGES = 8;

	localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

	// Q30 coefficients of sin(pi/2 x), x^1 up to x^11
	localparam logic signed [31:0] SINE_COEF [6] = '{
		32'sd1686629713,
		-32'sd693598668,
		32'sd85569306,
		-32'sd5026995,
		32'sd172271,
		-32'sd3864
	};

	// Q30 product, rounded to nearest, ties away from zero
	function automatic logic signed [31:0] mul_q30(
		input logic signed [31:0] a,
		input logic signed [31:0] b
	);
		logic signed [63:0] prod;
		logic signed [63:0] rnd;
		prod = 64'(a) * 64'(b);
		rnd  = prod + (prod[63] ? 64'sd536870911 : 64'sd536870912);
		return signed'(rnd[61:30]);
	endfunction

endpackage

// File: hw/rtl/euler_to_rotation_basis.sv
// Top level: yaw-pitch-roll angles to forward, left and up basis vectors.
//
// channel  dir  fields (tdata, lowest bits first)
// s_axis   in   yaw_angle, pitch_angle, roll_angle
// m_axis   out  fwd_x, fwd_y, fwd_z, left_x, left_y, left_z, up_x, up_y, up_z
//
// Eleven register stages: eight in the sine units (table-free polynomial, at most
// one multiply per stage), two product stages, one sum and rounding stage that is
// also the output register. One transfer per cycle sustained while m_axis_tready is high.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles are squeezed out while the output stalls; s_axis_tready follows that chain.
// arst_n clears the stage valid bits only; payload registers are not reset.
`timescale 1ns / 1ps

module euler_to_rotation_basis #(
	parameter int ANGLE_BITS     = etrb_pkg::DEF_ANGLE_BITS,
	parameter int COMPONENT_BITS = etrb_pkg::DEF_COMPONENT_BITS,
	localparam int IN_W  = ((3 * ANGLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((9 * COMPONENT_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// yaw_angle, pitch_angle, roll_angle
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// fwd_x, fwd_y, fwd_z, left_x, left_y, left_z, up_x, up_y, up_z
	output logic [OUT_W-1:0] m_axis_tdata
);

	localparam int NS  = 11;
	localparam int SS  = etrb_pkg::SINE_STAGES;
	localparam int CB  = COMPONENT_BITS;
	localparam int F   = COMPONENT_BITS - 1;
	localparam int SHL = (F >= 30) ? (F - 30) : 0;
	localparam int SHR = (F >= 30) ? 0 : (30 - F);
	localparam logic signed [39:0] RND = (F >= 30) ? 40'sd0
		: (40'sd1 <<< ((SHR > 0) ? (SHR - 1) : 0));
	localparam logic signed [39:0] SAT_HI = (40'sd1 <<< F) - 40'sd1;
	localparam logic signed [39:0] SAT_LO = -(40'sd1 <<< F);

	function automatic logic signed [CB-1:0] to_out(input logic signed [32:0] v);
		logic signed [39:0] w;
		logic signed [39:0] r;
		w = 40'(v);
		if (F >= 30) begin
			r = w <<< SHL;
		end else begin
			r = (w + RND) >>> SHR;
		end
		if (r > SAT_HI) begin
			r = SAT_HI;
		end
		if (r < SAT_LO) begin
			r = SAT_LO;
		end
		return r[CB-1:0];
	endfunction

	logic [NS:1] vld_s;
	logic [NS:1] adv;

	always_comb begin
		adv[NS] = !vld_s[NS] || m_axis_tready;
		for (int i = NS - 1; i >= 1; i--) begin
			adv[i] = !vld_s[i] || adv[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= (vld_s & ~adv) | ({vld_s[NS-1:1], s_axis_tvalid} & adv);
		end
	end

	assign s_axis_tready = adv[1];
	assign m_axis_tvalid = vld_s[NS];

	logic [ANGLE_BITS-1:0] yaw_angle;
	logic [ANGLE_BITS-1:0] pitch_angle;
	logic [ANGLE_BITS-1:0] roll_angle;

	assign yaw_angle   = s_axis_tdata[ANGLE_BITS-1:0];
	assign pitch_angle = s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS];
	assign roll_angle  = s_axis_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS];

	logic signed [31:0] sy, cy, sp, cp, sr, cr;

	etrb_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_yaw (
		.clk(clk), .en(adv[SS:1]),
		.quad(yaw_angle[ANGLE_BITS-1:ANGLE_BITS-2]),
		.frac(yaw_angle[ANGLE_BITS-3:0]), .sine(sy)
	);
	etrb_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_yaw (
		.clk(clk), .en(adv[SS:1]),
		.quad(yaw_angle[ANGLE_BITS-1:ANGLE_BITS-2] + 2'd1),
		.frac(yaw_angle[ANGLE_BITS-3:0]), .sine(cy)
	);
	etrb_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_pitch (
		.clk(clk), .en(adv[SS:1]),
		.quad(pitch_angle[ANGLE_BITS-1:ANGLE_BITS-2]),
		.frac(pitch_angle[ANGLE_BITS-3:0]), .sine(sp)
	);
	etrb_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_pitch (
		.clk(clk), .en(adv[SS:1]),
		.quad(pitch_angle[ANGLE_BITS-1:ANGLE_BITS-2] + 2'd1),
		.frac(pitch_angle[ANGLE_BITS-3:0]), .sine(cp)
	);
	etrb_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_roll (
		.clk(clk), .en(adv[SS:1]),
		.quad(roll_angle[ANGLE_BITS-1:ANGLE_BITS-2]),
		.frac(roll_angle[ANGLE_BITS-3:0]), .sine(sr)
	);
	etrb_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_roll (
		.clk(clk), .en(adv[SS:1]),
		.quad(roll_angle[ANGLE_BITS-1:ANGLE_BITS-2] + 2'd1),
		.frac(roll_angle[ANGLE_BITS-3:0]), .sine(cr)
	);

	// pairwise products
	logic signed [31:0] sy_s9, cy_s9, sp_s9, srsp_s9, crsp_s9;
	logic signed [31:0] cycp_s9, sycp_s9, sycr_s9, crcy_s9, cpsr_s9, srsy_s9, srcy_s9, crcp_s9;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			sy_s9   <= sy;
			cy_s9   <= cy;
			sp_s9   <= sp;
			srsp_s9 <= etrb_pkg::mul_q30(sr, sp);
			crsp_s9 <= etrb_pkg::mul_q30(cr, sp);
			cycp_s9 <= etrb_pkg::mul_q30(cy, cp);
			sycp_s9 <= etrb_pkg::mul_q30(sy, cp);
			sycr_s9 <= etrb_pkg::mul_q30(sy, cr);
			crcy_s9 <= etrb_pkg::mul_q30(cr, cy);
			cpsr_s9 <= etrb_pkg::mul_q30(cp, sr);
			srsy_s9 <= etrb_pkg::mul_q30(sr, sy);
			srcy_s9 <= etrb_pkg::mul_q30(sr, cy);
			crcp_s9 <= etrb_pkg::mul_q30(cr, cp);
		end
	end

	// three-factor products
	logic signed [31:0] sp_s10, cycp_s10, sycp_s10, sycr_s10, crcy_s10;
	logic signed [31:0] cpsr_s10, srsy_s10, srcy_s10, crcp_s10;
	logic signed [31:0] srspcy_s10, srspsy_s10, crspcy_s10, crspsy_s10;

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			sp_s10     <= sp_s9;
			cycp_s10   <= cycp_s9;
			sycp_s10   <= sycp_s9;
			sycr_s10   <= sycr_s9;
			crcy_s10   <= crcy_s9;
			cpsr_s10   <= cpsr_s9;
			srsy_s10   <= srsy_s9;
			srcy_s10   <= srcy_s9;
			crcp_s10   <= crcp_s9;
			srspcy_s10 <= etrb_pkg::mul_q30(srsp_s9, cy_s9);
			srspsy_s10 <= etrb_pkg::mul_q30(srsp_s9, sy_s9);
			crspcy_s10 <= etrb_pkg::mul_q30(crsp_s9, cy_s9);
			crspsy_s10 <= etrb_pkg::mul_q30(crsp_s9, sy_s9);
		end
	end

	// sums, rounding and saturation into the output register
	logic signed [CB-1:0] fwd_x_s11, fwd_y_s11, fwd_z_s11;
	logic signed [CB-1:0] left_x_s11, left_y_s11, left_z_s11;
	logic signed [CB-1:0] up_x_s11, up_y_s11, up_z_s11;

	always_ff @(posedge clk) begin
		if (adv[11]) begin
			fwd_x_s11  <= to_out(33'(cycp_s10));
			fwd_y_s11  <= to_out(33'(sycp_s10));
			fwd_z_s11  <= to_out(-33'(sp_s10));
			left_x_s11 <= to_out(33'(srspcy_s10) - 33'(sycr_s10));
			left_y_s11 <= to_out(33'(crcy_s10) + 33'(srspsy_s10));
			left_z_s11 <= to_out(33'(cpsr_s10));
			up_x_s11   <= to_out(33'(srsy_s10) + 33'(crspcy_s10));
			up_y_s11   <= to_out(33'(crspsy_s10) - 33'(srcy_s10));
			up_z_s11   <= to_out(33'(crcp_s10));
		end
	end

	assign m_axis_tdata = OUT_W'({up_z_s11, up_y_s11, up_x_s11,
		left_z_s11, left_y_s11, left_x_s11,
		fwd_z_s11, fwd_y_s11, fwd_x_s11});

	a_full_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_s) && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while pipeline full and stalled");

	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with empty output stage");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> vld_s[1])
		else $error("accepted transfer lost at first stage");

	a_hold_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> vld_s[1])
		else $error("first stage holds without an item");

endmodule

// File: hw/rtl/etrb_sine.sv
// Pipelined quarter-wave sine unit, Q30 result, one angle per cycle while its stage enables are high.
`timescale 1ns / 1ps

module etrb_sine #(
	parameter int ANGLE_BITS = etrb_pkg::DEF_ANGLE_BITS
) (
	input  logic                                clk,
	input  logic [etrb_pkg::SINE_STAGES:1]      en,
	input  logic [1:0]                          quad,
	input  logic [ANGLE_BITS-3:0]               frac,
	output logic signed [31:0]                  sine
);

	logic [31:0]        xf;
	logic signed [31:0] x_c;
	logic signed [31:0] r_c;
	logic signed [31:0] sine_c;

	logic signed [31:0] x_s  [1:7];
	logic signed [31:0] x2_s [2:6];
	logic signed [31:0] p_s  [3:7];
	logic               neg_s [1:7];
	logic signed [31:0] sine_s8;

	always_comb begin
		xf  = 32'(frac) << (32 - ANGLE_BITS);
		x_c = quad[0] ? (etrb_pkg::ONE_Q30 - signed'(xf)) : signed'(xf);
	end

	always_comb begin
		r_c = etrb_pkg::mul_q30(p_s[7], x_s[7]);
		if (r_c < 0) begin
			r_c = '0;
		end else if (r_c > etrb_pkg::ONE_Q30) begin
			r_c = etrb_pkg::ONE_Q30;
		end
		sine_c = neg_s[7] ? -r_c : r_c;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			x_s[1]   <= x_c;
			neg_s[1] <= quad[1];
		end
		if (en[2]) begin
			x_s[2]   <= x_s[1];
			neg_s[2] <= neg_s[1];
			x2_s[2]  <= etrb_pkg::mul_q30(x_s[1], x_s[1]);
		end
		if (en[3]) begin
			x_s[3]   <= x_s[2];
			neg_s[3] <= neg_s[2];
			x2_s[3]  <= x2_s[2];
			p_s[3]   <= etrb_pkg::SINE_COEF[4]
				+ etrb_pkg::mul_q30(etrb_pkg::SINE_COEF[5], x2_s[2]);
		end
		if (en[4]) begin
			x_s[4]   <= x_s[3];
			neg_s[4] <= neg_s[3];
			x2_s[4]  <= x2_s[3];
			p_s[4]   <= etrb_pkg::SINE_COEF[3] + etrb_pkg::mul_q30(p_s[3], x2_s[3]);
		end
		if (en[5]) begin
			x_s[5]   <= x_s[4];
			neg_s[5] <= neg_s[4];
			x2_s[5]  <= x2_s[4];
			p_s[5]   <= etrb_pkg::SINE_COEF[2] + etrb_pkg::mul_q30(p_s[4], x2_s[4]);
		end
		if (en[6]) begin
			x_s[6]   <= x_s[5];
			neg_s[6] <= neg_s[5];
			x2_s[6]  <= x2_s[5];
			p_s[6]   <= etrb_pkg::SINE_COEF[1] + etrb_pkg::mul_q30(p_s[5], x2_s[5]);
		end
		if (en[7]) begin
			x_s[7]   <= x_s[6];
			neg_s[7] <= neg_s[6];
			p_s[7]   <= etrb_pkg::SINE_COEF[0] + etrb_pkg::mul_q30(p_s[6], x2_s[6]);
		end
		if (en[8]) begin
			sine_s8 <= sine_c;
		end
	end

	assign sine = sine_s8;

endmodule

// File: verif/euler_basis_checker.sv
// Checker: predicts the rotation basis of each accepted angle triple and compares results.
`timescale 1ns / 1ps

module euler_basis_checker #(
	parameter int ANGLE_BITS     = etrb_pkg::DEF_ANGLE_BITS,
	parameter int COMPONENT_BITS = etrb_pkg::DEF_COMPONENT_BITS,
	localparam int IN_W  = ((3 * ANGLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((9 * COMPONENT_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	// yaw_angle, pitch_angle, roll_angle
	input  logic [IN_W-1:0]  in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	// fwd_x, fwd_y, fwd_z, left_x, left_y, left_z, up_x, up_y, up_z
	input  logic [OUT_W-1:0] out_data,
	output int               mismatches,
	output int               outstanding
);

	localparam int FRAC     = COMPONENT_BITS - 1;
	localparam int UP_SH    = (FRAC >= 30) ? FRAC - 30 : 0;
	localparam int DN_SH    = (FRAC < 30) ? 30 - FRAC : 1;
	localparam int NUM_COMP = 9;
	localparam int BASIS_W  = NUM_COMP * COMPONENT_BITS;
	localparam int MAX_SHOWN = 10;

	localparam longint Q30_ONE = 64'sd1 <<< 30;
	// odd polynomial for sin(pi/2 x) in Q30, x^1 first
	localparam longint POLY_Q30 [6] = '{
		64'sd1686629713, -64'sd693598668, 64'sd85569306,
		-64'sd5026995, 64'sd172271, -64'sd3864
	};

	typedef logic signed [COMPONENT_BITS-1:0] comp_t;

	// packed from the top down, so fwd_x sits in the lowest bits
	typedef struct packed {
		comp_t up_z;
		comp_t up_y;
		comp_t up_x;
		comp_t left_z;
		comp_t left_y;
		comp_t left_x;
		comp_t fwd_z;
		comp_t fwd_y;
		comp_t fwd_x;
	} basis_t;

	string comp_names [NUM_COMP] = '{
		"fwd_x", "fwd_y", "fwd_z", "left_x", "left_y", "left_z", "up_x", "up_y", "up_z"
	};

	basis_t expected_basis_q [$];

	int mismatch_count = 0;
	int pending_count  = 0;

	assign mismatches  = mismatch_count;
	assign outstanding = pending_count;

	// rounded to nearest, ties away from zero
	function automatic longint q30_mul(input longint a, input longint b);
		bit                neg;
		longint unsigned   ma;
		longint unsigned   mb;
		longint unsigned   r;
		neg = (a < 0) != (b < 0);
		ma  = (a < 0) ? -a : a;
		mb  = (b < 0) ? -b : b;
		r   = (ma * mb + (64'd1 << 29)) >> 30;
		return neg ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint quarter_wave_sine(input logic [1:0] quad,
			input longint unsigned frac);
		longint x;
		longint x2;
		longint acc;
		longint r;
		int     k;
		x = longint'(frac << (32 - ANGLE_BITS));
		if (quad[0]) begin
			x = Q30_ONE - x;
		end
		x2  = q30_mul(x, x);
		acc = POLY_Q30[5];
		for (k = 4; k >= 0; k--) begin
			acc = POLY_Q30[k] + q30_mul(acc, x2);
		end
		r = q30_mul(acc, x);
		if (r < 0) begin
			r = 0;
		end
		if (r > Q30_ONE) begin
			r = Q30_ONE;
		end
		return quad[1] ? -r : r;
	endfunction

	function automatic void angle_sin_cos(input logic [ANGLE_BITS-1:0] ang,
			output longint s, output longint c);
		logic [1:0]      quad;
		longint unsigned frac;
		quad = ang[ANGLE_BITS-1 -: 2];
		frac = ang[ANGLE_BITS-3:0];
		s    = quarter_wave_sine(quad, frac);
		c    = quarter_wave_sine(quad + 2'd1, frac);
	endfunction

	// Q30 to output format, ties toward plus infinity, saturated
	function automatic comp_t to_component(input longint v);
		longint r;
		longint hi;
		longint lo;
		hi = (64'sd1 <<< FRAC) - 1;
		lo = -(64'sd1 <<< FRAC);
		if (FRAC >= 30) begin
			r = v <<< UP_SH;
		end else begin
			r = (v + (64'sd1 <<< (DN_SH - 1))) >>> DN_SH;
		end
		if (r > hi) begin
			r = hi;
		end
		if (r < lo) begin
			r = lo;
		end
		return r[COMPONENT_BITS-1:0];
	endfunction

	function automatic basis_t rotation_basis_of(input logic [IN_W-1:0] angles);
		longint sy, cy, sp, cp, sr, cr;
		longint srsp, crsp;
		basis_t b;
		angle_sin_cos(angles[0 +: ANGLE_BITS], sy, cy);
		angle_sin_cos(angles[ANGLE_BITS +: ANGLE_BITS], sp, cp);
		angle_sin_cos(angles[2 * ANGLE_BITS +: ANGLE_BITS], sr, cr);
		srsp     = q30_mul(sr, sp);
		crsp     = q30_mul(cr, sp);
		b.fwd_x  = to_component(q30_mul(cy, cp));
		b.fwd_y  = to_component(q30_mul(sy, cp));
		b.fwd_z  = to_component(-sp);
		b.left_x = to_component(q30_mul(srsp, cy) - q30_mul(sy, cr));
		b.left_y = to_component(q30_mul(cr, cy) + q30_mul(srsp, sy));
		b.left_z = to_component(q30_mul(cp, sr));
		b.up_x   = to_component(q30_mul(sr, sy) + q30_mul(crsp, cy));
		b.up_y   = to_component(q30_mul(crsp, sy) - q30_mul(sr, cy));
		b.up_z   = to_component(q30_mul(cr, cp));
		return b;
	endfunction

	always @(posedge clk) begin : compare_proc
		logic [BASIS_W-1:0] want;
		logic [BASIS_W-1:0] got;
		comp_t              w;
		comp_t              g;
		int                 i;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_basis_q.push_back(rotation_basis_of(in_data));
			end
			if (out_valid && out_ready) begin
				got = out_data[BASIS_W-1:0];
				if (expected_basis_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_SHOWN) begin
						$display("%0t: result with none expected: %h", $realtime, got);
					end
				end else begin
					want = expected_basis_q.pop_front();
					for (i = 0; i < NUM_COMP; i++) begin
						w = want[i * COMPONENT_BITS +: COMPONENT_BITS];
						g = got[i * COMPONENT_BITS +: COMPONENT_BITS];
						if (g !== w) begin
							mismatch_count++;
							if (mismatch_count <= MAX_SHOWN) begin
								$display("%0t: %s expected %0d got %0d", $realtime,
									comp_names[i], w, g);
							end
						end
					end
				end
			end
			pending_count = expected_basis_q.size();
		end
	end

endmodule

// File: verif/euler_to_rotation_basis_test.sv
// Testbench top: drives angle triples into the rotation basis block and gives the verdict.
`timescale 1ns / 1ps

module euler_to_rotation_basis_test;

	localparam int AB    = etrb_pkg::DEF_ANGLE_BITS;
	localparam int CB    = etrb_pkg::DEF_COMPONENT_BITS;
	localparam int IN_W  = ((3 * AB + 7) / 8) * 8;
	localparam int OUT_W = ((9 * CB + 7) / 8) * 8;

	localparam int RANDOM_PER_PHASE = 134;
	localparam int HOLD_AT          = 300;
	localparam int HOLD_CYCLES      = 90;
	localparam int DRAIN_CYCLES     = 30;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	// yaw_angle, pitch_angle, roll_angle
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	// fwd_x, fwd_y, fwd_z, left_x, left_y, left_z, up_x, up_y, up_z
	logic [OUT_W-1:0] m_axis_tdata;

	int mismatches;
	int outstanding;
	int items_sent = 0;
	int tx_idle_pct = 11;
	int rx_idle_pct = 70;
	int hold_left = 0;
	bit hold_done = 1'b0;

	always #2 clk = ~clk;

	euler_to_rotation_basis dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	euler_basis_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_data     (s_axis_tdata),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	task automatic send_angles(input logic [AB-1:0] yaw, input logic [AB-1:0] pitch,
			input logic [AB-1:0] roll);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_W'({roll, pitch, yaw});
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		items_sent++;
		@(negedge clk);
	endtask

	// mostly uniform, otherwise close to a quadrant boundary
	function automatic logic [AB-1:0] random_angle();
		logic [AB-1:0] base;
		if ($urandom_range(99) < 60) begin
			return AB'($urandom);
		end
		base = AB'($urandom_range(3)) << (AB - 2);
		return base + AB'($urandom_range(64)) - AB'(32);
	endfunction

	// receiver: random stalls, plus one long hold-off to back up the pipeline
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (!hold_done && items_sent >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int ph;
		int n;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_angles(16'h0000, 16'h0000, 16'h0000);
		send_angles(16'h4000, 16'h0000, 16'h0000);
		send_angles(16'h8000, 16'h0000, 16'h0000);
		send_angles(16'hC000, 16'h0000, 16'h0000);
		send_angles(16'h0000, 16'h4000, 16'h0000);
		send_angles(16'h0000, 16'hC000, 16'h0000);
		send_angles(16'h0000, 16'h0000, 16'h4000);
		send_angles(16'h0000, 16'h0000, 16'h8000);
		send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_angles(16'h0001, 16'h0001, 16'h0001);
		send_angles(16'h3FFF, 16'h7FFF, 16'hBFFF);
		send_angles(16'h4001, 16'h8001, 16'hC001);
		send_angles(16'h2000, 16'h2000, 16'h2000);
		send_angles(16'hE000, 16'h6000, 16'hA000);
		send_angles(16'h5555, 16'hAAAA, 16'h5555);
		send_angles(16'hAAAA, 16'h5555, 16'hAAAA);
		send_angles(16'h8000, 16'h8000, 16'h8000);
		send_angles(16'h4000, 16'h4000, 16'h4000);
		send_angles(16'hC000, 16'hC000, 16'hC000);
		send_angles(16'h0000, 16'hFFFF, 16'h8000);

		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 11;
					rx_idle_pct = 70;
				end
				1: begin
					tx_idle_pct = 70;
					rx_idle_pct = 11;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				send_angles(random_angle(), random_angle(), random_angle());
			end
		end
		s_axis_tvalid <= 1'b0;

		while (outstanding != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/etrb_pkg.sv
hw/rtl/etrb_sine.sv
hw/rtl/euler_to_rotation_basis.sv
verif/euler_basis_checker.sv
verif/euler_to_rotation_basis_test.sv
